### sv/tmwd_pkg.sv
// ----------------------------------------------------------------------------
// Tilt median wheel duty package
// Shared widths, types, register codes and arithmetic constants.
// ----------------------------------------------------------------------------
package tmwd_pkg;

    localparam int ANGLE_W     = 9;
    localparam int DUTY_W      = 10;
    localparam int CFG_W       = 9;
    localparam int CFG_INDEX_W = 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int LANES       = 2;
    localparam int LANE_PITCH  = 0;
    localparam int LANE_ROLL   = 1;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [DUTY_W-1:0]  duty_t;
    typedef logic [CFG_W-1:0]          cfg_t;

    localparam logic [CFG_INDEX_W-1:0] REG_DEAD_BAND  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DUTY_LIMIT = 1'b1;

    localparam cfg_t DEAD_BAND_RST  = 9'd20;
    localparam cfg_t DUTY_LIMIT_RST = 9'd499;

    // angle map: (v + 90) * 254 / 180 - 127
    localparam int MAP_PROD_W = 19;
    localparam int MAP_MAG_W  = 17;
    localparam int MAP_Q_W    = 10;
    localparam int MAP_M_W    = 11;
    localparam int MAP_SHIFT  = 24;
    localparam logic signed [MAP_PROD_W-1:0] MAP_OFFSET = 19'sd90;
    localparam logic signed [MAP_PROD_W-1:0] MAP_SCALE  = 19'sd254;
    localparam logic [MAP_MAG_W-1:0]         MAP_RECIP  = 17'd93207;
    localparam logic signed [MAP_M_W-1:0]    MAP_BIAS   = 11'sd127;

    // duty map: (x + 127) * 998 / 254 - 499
    localparam int MIX_W       = 12;
    localparam int DUTY_PROD_W = 22;
    localparam int DUTY_MAG_W  = 20;
    localparam int DUTY_Q_W    = 13;
    localparam int DUTY_D_W    = 14;
    localparam int DUTY_SHIFT  = 28;
    localparam int DUTY_RCP_W  = 21;
    localparam logic signed [MIX_W-1:0]       MIX_BIAS   = 12'sd127;
    localparam logic signed [DUTY_PROD_W-1:0] DUTY_SCALE = 22'sd998;
    localparam logic [DUTY_RCP_W-1:0]         DUTY_RECIP = 21'd1056833;
    localparam logic signed [DUTY_D_W-1:0]    DUTY_BIAS  = 14'sd499;

endpackage

### sv/tmwd_if.sv
// ----------------------------------------------------------------------------
// Tilt median wheel duty channels
// Valid/ready channels for tilt samples and wheel duty results.
// ----------------------------------------------------------------------------
interface tmwd_in_if;
    import tmwd_pkg::*;

    logic   valid;
    logic   ready;
    angle_t pitch_angle;
    angle_t roll_angle;

    modport source (output valid, output pitch_angle, output roll_angle, input ready);
    modport sink   (input valid, input pitch_angle, input roll_angle, output ready);
endinterface

interface tmwd_out_if;
    import tmwd_pkg::*;

    logic  valid;
    logic  ready;
    duty_t duty_a;
    duty_t duty_b;

    modport source (output valid, output duty_a, output duty_b, input ready);
    modport sink   (input valid, input duty_a, input duty_b, output ready);
endinterface

### sv/tmwd_front.sv
// ----------------------------------------------------------------------------
// Tilt median wheel duty front end
// Collects tilt transactions into windows and pushes each full window.
// ----------------------------------------------------------------------------
module tmwd_front #(
    parameter int WINDOW_LEN = 5
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    tmwd_in_if.sink                                      tilt,
    input  logic                                         full,
    output logic                                         push,
    output logic [2*WINDOW_LEN*tmwd_pkg::ANGLE_W-1:0]    push_data
);
    import tmwd_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_LEN);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(WINDOW_LEN - 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    angle_t           pitch_win_reg [WINDOW_LEN];
    angle_t           roll_win_reg  [WINDOW_LEN];
    logic             accept;

    always_comb
    begin
        tilt.ready = (count_reg != LAST) || !full;
        accept     = tilt.valid && tilt.ready;
        push       = accept && (count_reg == LAST);
        count_next = count_reg;
        if (accept)
        begin
            count_next = (count_reg == LAST) ? '0 : count_reg + 1'b1;
        end
    end

    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN - 1; i++)
        begin
            push_data[i*ANGLE_W +: ANGLE_W]                = pitch_win_reg[i];
            push_data[(WINDOW_LEN+i)*ANGLE_W +: ANGLE_W]   = roll_win_reg[i];
        end
        push_data[(WINDOW_LEN-1)*ANGLE_W +: ANGLE_W]       = tilt.pitch_angle;
        push_data[(2*WINDOW_LEN-1)*ANGLE_W +: ANGLE_W]     = tilt.roll_angle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pitch_win_reg[count_reg] <= tilt.pitch_angle;
            roll_win_reg[count_reg]  <= tilt.roll_angle;
        end
    end

    a_push_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> count_reg == '0)
        else $error("window count did not restart after push");

endmodule

### sv/tmwd_queue.sv
// ----------------------------------------------------------------------------
// Tilt median wheel duty window queue
// Short queue of full windows between the front end and the back end.
// ----------------------------------------------------------------------------
module tmwd_queue #(
    parameter int DATA_W = 90
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);
    import tmwd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_next;

    always_comb
    begin
        full        = (count_reg == CNT_FULL);
        empty       = (count_reg == '0);
        pop_data    = entry_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full window queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty window queue");

endmodule

### sv/tmwd_back.sv
// ----------------------------------------------------------------------------
// Tilt median wheel duty back end
// Sorts a window by odd-even passes, maps medians, mixes and clips duties.
// ----------------------------------------------------------------------------
module tmwd_back #(
    parameter int WINDOW_LEN = 5
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         empty,
    output logic                                         pop,
    input  logic [2*WINDOW_LEN*tmwd_pkg::ANGLE_W-1:0]    pop_data,
    input  tmwd_pkg::cfg_t                               dead_band,
    input  tmwd_pkg::cfg_t                               duty_limit,
    tmwd_out_if.source                                   duty
);
    import tmwd_pkg::*;

    localparam int MID    = WINDOW_LEN / 2;
    localparam int PASS_W = $clog2(WINDOW_LEN);
    localparam logic [PASS_W-1:0] LAST_PASS = PASS_W'(WINDOW_LEN - 1);

    localparam logic [2:0] B_IDLE     = 3'd0;
    localparam logic [2:0] B_SORT     = 3'd1;
    localparam logic [2:0] B_MAP_MUL  = 3'd2;
    localparam logic [2:0] B_MAP_DIV  = 3'd3;
    localparam logic [2:0] B_MIX      = 3'd4;
    localparam logic [2:0] B_DUTY_MUL = 3'd5;
    localparam logic [2:0] B_DUTY_DIV = 3'd6;
    localparam logic [2:0] B_CLIP     = 3'd7;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [PASS_W-1:0] pass_reg;
    logic [PASS_W-1:0] pass_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;

    angle_t                         win_reg  [LANES][WINDOW_LEN];
    angle_t                         win_load [LANES][WINDOW_LEN];
    angle_t                         win_sort [LANES][WINDOW_LEN];
    logic [MAP_MAG_W-1:0]           mmag_reg [LANES];
    logic                           mneg_reg [LANES];
    logic signed [MAP_M_W-1:0]      m_reg    [LANES];
    logic signed [MIX_W-1:0]        t_reg    [LANES];
    logic [DUTY_MAG_W-1:0]          dmag_reg [LANES];
    logic                           dneg_reg [LANES];
    logic signed [DUTY_D_W-1:0]     d_reg    [LANES];
    duty_t                          duty_a_reg;
    duty_t                          duty_b_reg;

    logic signed [MAP_PROD_W-1:0]   map_prod  [LANES];
    logic [MAP_MAG_W-1:0]           mmag_next [LANES];
    logic [MAP_MAG_W+MAP_MAG_W-1:0] map_qprod [LANES];
    logic signed [MAP_M_W-1:0]      map_q     [LANES];
    logic signed [MAP_M_W-1:0]      m_next    [LANES];
    logic signed [MIX_W-1:0]        t_next    [LANES];
    logic signed [DUTY_PROD_W-1:0]  duty_prod [LANES];
    logic [DUTY_MAG_W-1:0]          dmag_next [LANES];
    logic [DUTY_MAG_W+DUTY_RCP_W-1:0] duty_qprod [LANES];
    logic signed [DUTY_D_W-1:0]     duty_q    [LANES];
    logic signed [DUTY_D_W-1:0]     d_next    [LANES];
    logic signed [DUTY_D_W-1:0]     clip_val  [LANES];
    logic signed [DUTY_D_W-1:0]     db_s;
    logic signed [DUTY_D_W-1:0]     lim_s;

    always_comb
    begin
        out_free       = !out_valid_reg || duty.ready;
        pop            = (state_reg == B_IDLE) && !empty;
        state_next     = state_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg && !duty.ready;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    state_next = B_SORT;
                    pass_next  = '0;
                end
            end
            B_SORT:
            begin
                pass_next = pass_reg + 1'b1;
                if (pass_reg == LAST_PASS)
                begin
                    state_next = B_MAP_MUL;
                end
            end
            B_MAP_MUL:  state_next = B_MAP_DIV;
            B_MAP_DIV:  state_next = B_MIX;
            B_MIX:      state_next = B_DUTY_MUL;
            B_DUTY_MUL: state_next = B_DUTY_DIV;
            B_DUTY_DIV: state_next = B_CLIP;
            B_CLIP:
            begin
                if (out_free)
                begin
                    state_next     = B_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:    state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        db_s  = $signed({5'b0, dead_band});
        lim_s = $signed({5'b0, duty_limit});
        for (int l = 0; l < LANES; l++)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                win_load[l][i] = pop_data[(l*WINDOW_LEN+i)*ANGLE_W +: ANGLE_W];
                win_sort[l][i] = win_reg[l][i];
            end
            // odd-even transposition: disjoint pairs, parity set by pass
            for (int i = 0; i < WINDOW_LEN - 1; i++)
            begin
                if ((1'(i % 2) == pass_reg[0]) && (win_reg[l][i] > win_reg[l][i+1]))
                begin
                    win_sort[l][i]   = win_reg[l][i+1];
                    win_sort[l][i+1] = win_reg[l][i];
                end
            end

            map_prod[l]  = (MAP_PROD_W'(win_reg[l][MID]) + MAP_OFFSET) * MAP_SCALE;
            mmag_next[l] = map_prod[l][MAP_PROD_W-1] ? MAP_MAG_W'(-map_prod[l])
                                                     : MAP_MAG_W'(map_prod[l]);
            map_qprod[l] = (MAP_MAG_W+MAP_MAG_W)'(mmag_reg[l]) *
                           (MAP_MAG_W+MAP_MAG_W)'(MAP_RECIP);
            map_q[l]     = $signed({1'b0, map_qprod[l][MAP_SHIFT +: MAP_Q_W]});
            m_next[l]    = (mneg_reg[l] ? -map_q[l] : map_q[l]) - MAP_BIAS;

            duty_prod[l]  = DUTY_PROD_W'(t_reg[l]) * DUTY_SCALE;
            dmag_next[l]  = duty_prod[l][DUTY_PROD_W-1] ? DUTY_MAG_W'(-duty_prod[l])
                                                        : DUTY_MAG_W'(duty_prod[l]);
            duty_qprod[l] = (DUTY_MAG_W+DUTY_RCP_W)'(dmag_reg[l]) *
                            (DUTY_MAG_W+DUTY_RCP_W)'(DUTY_RECIP);
            duty_q[l]     = $signed({1'b0, duty_qprod[l][DUTY_SHIFT +: DUTY_Q_W]});
            d_next[l]     = (dneg_reg[l] ? -duty_q[l] : duty_q[l]) - DUTY_BIAS;

            // deadband first, then saturate
            clip_val[l] = d_reg[l];
            if ((d_reg[l] < db_s) && (d_reg[l] > -db_s))
            begin
                clip_val[l] = '0;
            end
            if (clip_val[l] > lim_s)
            begin
                clip_val[l] = lim_s;
            end
            if (clip_val[l] < -lim_s)
            begin
                clip_val[l] = -lim_s;
            end
        end
        t_next[0] = MIX_W'(m_reg[LANE_ROLL]) - MIX_W'(m_reg[LANE_PITCH]) + MIX_BIAS;
        t_next[1] = -MIX_W'(m_reg[LANE_PITCH]) - MIX_W'(m_reg[LANE_ROLL]) + MIX_BIAS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (pop)
            begin
                win_reg[l] <= win_load[l];
            end
            else if (state_reg == B_SORT)
            begin
                win_reg[l] <= win_sort[l];
            end
            if (state_reg == B_MAP_MUL)
            begin
                mmag_reg[l] <= mmag_next[l];
                mneg_reg[l] <= map_prod[l][MAP_PROD_W-1];
            end
            if (state_reg == B_MAP_DIV)
            begin
                m_reg[l] <= m_next[l];
            end
            if (state_reg == B_MIX)
            begin
                t_reg[l] <= t_next[l];
            end
            if (state_reg == B_DUTY_MUL)
            begin
                dmag_reg[l] <= dmag_next[l];
                dneg_reg[l] <= duty_prod[l][DUTY_PROD_W-1];
            end
            if (state_reg == B_DUTY_DIV)
            begin
                d_reg[l] <= d_next[l];
            end
        end
        if ((state_reg == B_CLIP) && out_free)
        begin
            duty_a_reg <= clip_val[0][DUTY_W-1:0];
            duty_b_reg <= clip_val[1][DUTY_W-1:0];
        end
    end

    assign duty.valid  = out_valid_reg;
    assign duty.duty_a = duty_a_reg;
    assign duty.duty_b = duty_b_reg;

    a_pop_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == B_SORT) && (pass_reg == '0))
        else $error("window pop did not start the sort");

    a_clip_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLIP) && out_free |=> out_valid_reg && (state_reg == B_IDLE))
        else $error("clipped duties not registered for output");

endmodule

### sv/tilt_median_wheel_duty_top.sv
// Front end takes one tilt transaction per cycle; a window queue of two decouples it,
// though the last transaction of a window waits while that queue is full.
// Back end handles one window at a time (a pop, WINDOW_LEN odd-even sort passes and
// six map/mix/clip steps); the clip step waits while the last duties are not taken.
// Reset clears window count, queue, sequencer and output valid; dead_band to 20,
// duty_limit to 499; window contents are not cleared.
// ----------------------------------------------------------------------------
// Tilt median wheel duty top level
// Median-of-window tilt smoothing and mixing into two signed wheel duties.
// ----------------------------------------------------------------------------
module tilt_median_wheel_duty_top #(
    parameter int WINDOW_LEN = 5
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tmwd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tmwd_pkg::CFG_W-1:0]           cfg_data,
    tmwd_in_if.sink                              tilt,
    tmwd_out_if.source                           duty
);
    import tmwd_pkg::*;

    localparam int WIN_W = 2 * WINDOW_LEN * ANGLE_W;

    cfg_t             dead_band_reg;
    cfg_t             duty_limit_reg;
    logic             push;
    logic             full;
    logic             pop;
    logic             empty;
    logic [WIN_W-1:0] push_data;
    logic [WIN_W-1:0] pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_band_reg  <= DEAD_BAND_RST;
            duty_limit_reg <= DUTY_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEAD_BAND:  dead_band_reg  <= cfg_data;
                REG_DUTY_LIMIT: duty_limit_reg <= cfg_data;
                default:        dead_band_reg  <= dead_band_reg;
            endcase
        end
    end

    tmwd_front #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .tilt      (tilt),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    tmwd_queue #(
        .DATA_W (WIN_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    tmwd_back #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .pop        (pop),
        .pop_data   (pop_data),
        .dead_band  (dead_band_reg),
        .duty_limit (duty_limit_reg),
        .duty       (duty)
    );

endmodule
